@@ hdl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and byte-class constants for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W = 21;

    typedef logic [7:0]      t_byte;
    typedef logic [CP_W-1:0] t_cp;
    typedef logic [1:0]      t_pend;

    localparam t_byte MASK_1B  = 8'h80;
    localparam t_byte MASK_2B  = 8'hE0;
    localparam t_byte LEAD_2B  = 8'hC0;
    localparam t_byte MASK_3B  = 8'hF0;
    localparam t_byte LEAD_3B  = 8'hE0;
    localparam t_byte MASK_4B  = 8'hF8;
    localparam t_byte LEAD_4B  = 8'hF0;

    localparam t_pend PEND_NONE = 2'd0;
    localparam t_pend PEND_ONE  = 2'd1;
    localparam t_pend PEND_TWO  = 2'd2;
    localparam t_pend PEND_THREE = 2'd3;

endpackage

@@ hdl/utf8d_byte_if.sv @@
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Byte channel into the decoder: one text byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
    logic                 valid;
    logic                 ready;
    utf8d_pkg::t_byte     data_byte;
    logic                 final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ hdl/utf8d_cp_if.sv @@
// ----------------------------------------------------------------------------
// utf8d_cp_if
// Code point channel out of the decoder.
// ----------------------------------------------------------------------------
interface utf8d_cp_if;
    logic                 valid;
    logic                 ready;
    utf8d_pkg::t_cp       code_point;
    logic                 text_end;

    modport source (output valid, output code_point, output text_end, input ready);
    modport sink   (input valid, input code_point, input text_end, output ready);
endinterface

@@ hdl/utf8_to_codepoint_decoder.sv @@
// A code point passes the byte register and then the result register once its last byte is taken.
// Throughput: 1 byte per cycle while the output is not stalled, set by the state update in the decode stage.
// Stalls on the output hold the byte register and then the input; no bubbles otherwise.
// Reset (i_rst_n low, synchronous) empties both registers and clears the open sequence.
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Byte-serial UTF-8 decoder: input register, decode stage, result register.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utf8d_byte_if.sink         i_in,
    utf8d_cp_if.source         o_out
);

    logic                  r_in_valid;
    utf8d_pkg::t_byte      r_in_byte;
    logic                  r_in_final;

    utf8d_pkg::t_pend      r_pending;
    utf8d_pkg::t_pend      n_pending;
    utf8d_pkg::t_cp        r_partial;
    utf8d_pkg::t_cp        n_partial;

    logic                  r_out_valid;
    utf8d_pkg::t_cp        r_out_cp;
    logic                  r_out_end;

    logic                  w_step;
    logic                  w_emit;
    utf8d_pkg::t_cp        w_cp;
    utf8d_pkg::t_pend      w_dec;
    utf8d_pkg::t_cp        w_cont;

    assign w_step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_step;

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_cp;
    assign o_out.text_end   = r_out_end;

    assign w_dec = r_pending - 2'd1;

    always_comb begin
        w_cont = '0;
        case (w_dec)
            utf8d_pkg::PEND_NONE: w_cont = {15'd0, r_in_byte[5:0]};
            utf8d_pkg::PEND_ONE:  w_cont = {9'd0, r_in_byte[5:0], 6'd0};
            utf8d_pkg::PEND_TWO:  w_cont = {3'd0, r_in_byte[5:0], 12'd0};
            default:              w_cont = '0;
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        w_emit    = 1'b0;
        w_cp      = '0;
        if (r_pending == utf8d_pkg::PEND_NONE) begin
            if ((r_in_byte & utf8d_pkg::MASK_1B) == 8'h00) begin
                w_emit = 1'b1;
                w_cp   = {13'd0, r_in_byte};
            end else if ((r_in_byte & utf8d_pkg::MASK_2B) == utf8d_pkg::LEAD_2B) begin
                n_partial = {10'd0, r_in_byte[4:0], 6'd0};
                n_pending = utf8d_pkg::PEND_ONE;
            end else if ((r_in_byte & utf8d_pkg::MASK_3B) == utf8d_pkg::LEAD_3B) begin
                n_partial = {5'd0, r_in_byte[3:0], 12'd0};
                n_pending = utf8d_pkg::PEND_TWO;
            end else if ((r_in_byte & utf8d_pkg::MASK_4B) == utf8d_pkg::LEAD_4B) begin
                n_partial = {r_in_byte[2:0], 18'd0};
                n_pending = utf8d_pkg::PEND_THREE;
            end else begin
                w_emit = 1'b1;
            end
        end else begin
            n_pending = w_dec;
            n_partial = r_partial | w_cont;
            if (w_dec == utf8d_pkg::PEND_NONE) begin
                w_emit = 1'b1;
                w_cp   = n_partial;
            end
        end
        if (!w_emit && r_in_final) begin
            w_emit = 1'b1;
            w_cp   = n_partial;
        end
        if (w_emit) begin
            n_pending = utf8d_pkg::PEND_NONE;
            n_partial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= utf8d_pkg::PEND_NONE;
            r_partial <= '0;
        end else if (w_step) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_emit) begin
            r_out_cp  <= w_cp;
            r_out_end <= r_in_final;
        end
    end

`ifndef SYNTHESIS
    // a transfer carrying the last-byte flag always closes the sequence
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_final) |=> (r_pending == utf8d_pkg::PEND_NONE && r_partial == '0))
        else $error("sequence left open after final byte");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == utf8d_pkg::PEND_NONE) |-> (r_partial == '0))
        else $error("partial value not clear while idle");

    a_low_bits_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == utf8d_pkg::PEND_ONE) |-> (r_partial[5:0] == 6'd0))
        else $error("missing bits already set in open sequence");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");

    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_final) |=> (r_out_valid && r_out_end))
        else $error("final byte produced no result");
`endif

endmodule

@@ tb/utf8_to_codepoint_decoder_test.sv @@
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_test
// Feeds byte streams (well-formed UTF-8 sequences of all lengths, stray and
// invalid lead bytes, truncated sequences, texts ending mid-sequence) through
// the decoder under random sender gaps and receiver stalls. Each code point
// is checked against a decoder model kept in the bench.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_test;

    localparam utf8d_pkg::t_byte PAY_2B   = 8'h1F;
    localparam utf8d_pkg::t_byte PAY_3B   = 8'h0F;
    localparam utf8d_pkg::t_byte PAY_4B   = 8'h07;
    localparam utf8d_pkg::t_byte CONT_PAY = 8'h3F;
    localparam utf8d_pkg::t_byte CONT_TAG = 8'h80;
    localparam int    N_BYTES  = 1100;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    TAIL_CYCLES = 10;

    typedef struct {
        utf8d_pkg::t_byte b;
        logic  fin;
        bit    drain;
    } t_text_byte;

    typedef struct {
        utf8d_pkg::t_cp  cp;
        logic te;
    } t_cp_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_to_codepoint_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (cp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_text_byte text_bytes[$];
    t_cp_result pending_cps[$];
    bit         drain_next;

    // decoder model state
    utf8d_pkg::t_pend open_cnt;
    utf8d_pkg::t_cp   acc_cp;

    int  fail_cnt;
    int  cyc_cnt;
    int  bytes_sent;
    int  cps_checked;
    int  ends_seen;
    logic byte_xfer;

    function automatic bit decode_utf8_byte(input utf8d_pkg::t_byte b, input logic fin,
                                            output t_cp_result res);
        bit emit;
        emit   = 1'b0;
        res.cp = '0;
        res.te = fin;
        if (open_cnt == utf8d_pkg::PEND_NONE) begin
            if ((b & utf8d_pkg::MASK_1B) == 8'h00) begin
                emit   = 1'b1;
                res.cp = utf8d_pkg::t_cp'(b);
            end else if ((b & utf8d_pkg::MASK_2B) == utf8d_pkg::LEAD_2B) begin
                acc_cp   = utf8d_pkg::t_cp'(b & PAY_2B) << 6;
                open_cnt = utf8d_pkg::PEND_ONE;
            end else if ((b & utf8d_pkg::MASK_3B) == utf8d_pkg::LEAD_3B) begin
                acc_cp   = utf8d_pkg::t_cp'(b & PAY_3B) << 12;
                open_cnt = utf8d_pkg::PEND_TWO;
            end else if ((b & utf8d_pkg::MASK_4B) == utf8d_pkg::LEAD_4B) begin
                acc_cp   = utf8d_pkg::t_cp'(b & PAY_4B) << 18;
                open_cnt = utf8d_pkg::PEND_THREE;
            end else begin
                emit = 1'b1;
            end
        end else begin
            open_cnt = open_cnt - 2'd1;
            acc_cp   = acc_cp | (utf8d_pkg::t_cp'(b & CONT_PAY) << (6 * open_cnt));
            if (open_cnt == utf8d_pkg::PEND_NONE) begin
                emit   = 1'b1;
                res.cp = acc_cp;
            end
        end
        if (!emit && fin) begin
            emit   = 1'b1;
            res.cp = acc_cp;
        end
        if (emit) begin
            open_cnt = utf8d_pkg::PEND_NONE;
            acc_cp   = '0;
        end
        return emit;
    endfunction

    task automatic push_byte(input utf8d_pkg::t_byte b, input logic fin);
        t_text_byte t;
        t.b   = b;
        t.fin = fin;
        t.drain = drain_next;
        drain_next = 1'b0;
        text_bytes = {text_bytes, t};
    endtask

    task automatic push_random_text(input int n);
        int     cnt;
        int     len;
        int     keep;
        utf8d_pkg::t_byte  lead;
        utf8d_pkg::t_byte  r;
        cnt = 0;
        while (cnt < n) begin
            if (cnt % 350 == 0)
                drain_next = 1'b1;
            r = utf8d_pkg::t_byte'($urandom);
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: lead = r & ~utf8d_pkg::MASK_1B;
                    2: lead = (r & PAY_2B) | utf8d_pkg::LEAD_2B;
                    3: lead = (r & PAY_3B) | utf8d_pkg::LEAD_3B;
                    default: lead = (r & PAY_4B) | utf8d_pkg::LEAD_4B;
                endcase
                keep = len;
                if (len > 1 && $urandom_range(0, 99) < 5)
                    keep = $urandom_range(1, len - 1);
                push_byte(lead, $urandom_range(0, 99) < 3);
                cnt++;
                for (int k = 1; k < keep; k++) begin
                    push_byte(CONT_TAG | (utf8d_pkg::t_byte'($urandom) & CONT_PAY),
                              $urandom_range(0, 99) < 3);
                    cnt++;
                end
            end else begin
                push_byte(r, $urandom_range(0, 99) < 5);
                cnt++;
            end
        end
    endtask

    // input side: prediction on transfer, output side: check
    always @(posedge i_clk) begin
        t_cp_result res;
        t_cp_result want;
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("[utf8_to_codepoint_decoder] ERROR");
            $finish;
        end
        byte_xfer <= i_rst_n && byte_ch.valid && byte_ch.ready;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            bytes_sent++;
            if (decode_utf8_byte(byte_ch.data_byte, byte_ch.final_byte, res))
                pending_cps = {pending_cps, res};
        end
        if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
            if (pending_cps.size() == 0) begin
                $error("unexpected code point %h (text_end %b)",
                       cp_ch.code_point, cp_ch.text_end);
                fail_cnt++;
            end else begin
                want = pending_cps.pop_front();
                cps_checked++;
                if (cp_ch.text_end === 1'b1)
                    ends_seen++;
                if (cp_ch.code_point !== want.cp) begin
                    $error("code_point mismatch: expected %h, got %h",
                           want.cp, cp_ch.code_point);
                    fail_cnt++;
                end
                if (cp_ch.text_end !== want.te) begin
                    $error("text_end mismatch: expected %b, got %b",
                           want.te, cp_ch.text_end);
                    fail_cnt++;
                end
            end
        end
    end

    // byte sender: bursts with random gaps
    int burst_left;
    int gap_left;

    always @(negedge i_clk) begin
        t_text_byte t;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_xfer) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                byte_ch.valid <= 1'b0;
            end else if (text_bytes.size() == 0 ||
                         (text_bytes[0].drain && pending_cps.size() != 0)) begin
                byte_ch.valid <= 1'b0;
            end else begin
                t = text_bytes.pop_front();
                byte_ch.valid      <= 1'b1;
                byte_ch.data_byte  <= t.b;
                byte_ch.final_byte <= t.fin;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // code point receiver: always ready, coin toss, or held off
    int rx_mode;
    int rx_left;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
        end else if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left <= (rx_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 40);
            cp_ch.ready <= (rx_mode != 2);
        end else begin
            rx_left <= rx_left - 1;
            cp_ch.ready <= (rx_mode == 0) || (rx_mode == 1 && $urandom_range(0, 1) == 1);
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.final_byte = 1'b0;
        cp_ch.ready        = 1'b0;
        byte_xfer          = 1'b0;
        open_cnt           = utf8d_pkg::PEND_NONE;
        acc_cp             = '0;
        fail_cnt           = 0;
        cyc_cnt            = 0;
        bytes_sent         = 0;
        cps_checked        = 0;
        ends_seen          = 0;
        burst_left         = 0;
        gap_left           = 0;
        rx_mode            = 0;
        rx_left            = 0;
        drain_next         = 1'b0;

        // ASCII extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // two, three and four byte sequences, largest four byte value
        push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
        push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
        // stray continuations and 11111xxx
        push_byte(8'h80, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hFF, 1'b0);
        // lead byte taken as continuation
        push_byte(8'hC3, 1'b0); push_byte(8'hC3, 1'b0);
        // text ends mid-sequence, on ASCII, on invalid lead, on a lone lead
        push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
        push_byte(8'h41, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hF4, 1'b1);

        push_random_text(N_BYTES);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (!(text_bytes.size() == 0 && !byte_ch.valid && pending_cps.size() == 0))
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_cps.size() != 0) begin
            $error("%0d code points never arrived", pending_cps.size());
            fail_cnt++;
        end
        $display("Sent %0d bytes; checked %0d code points, %0d of them closing a text.",
                 bytes_sent, cps_checked, ends_seen);
        if (fail_cnt == 0) begin
            $display("[utf8_to_codepoint_decoder] OK");
        end else begin
            $display("[utf8_to_codepoint_decoder] ERROR");
        end
        $finish;
    end

endmodule
